// ===== rtl/float64_ieee_remainder_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binary64 remainder block
// Shared property wrappers; each check samples on its given clock (clk_i for FREM_ASSERT), off in reset.
// ---------------------------------------------------------------------------
`ifndef FLOAT64_IEEE_REMAINDER_DEFINES_SVH
`define FLOAT64_IEEE_REMAINDER_DEFINES_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define FREM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define FREM_ASSERT(lbl, prop, msg) \
  `FREM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/frem_pkg.sv =====
// ---------------------------------------------------------------------------
// Remainder package
// Constants and the job record passed from the front end to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package frem_pkg;

  localparam logic [62:0] ExpAll     = 63'h7FF0000000000000;
  localparam logic [63:0] QuietBit   = 64'h0008000000000000;
  localparam logic [63:0] DefaultNan = 64'h7FF8000000000000;
  localparam int unsigned ExpW       = 13;
  localparam int unsigned ManW       = 53;
  localparam int unsigned CntW       = 12;
  localparam logic signed [ExpW-1:0] MinExp  = -13'sd1074;
  localparam logic signed [ExpW-1:0] ExpBias = 13'sd1075;

  typedef struct packed {
    logic                   direct;  // result already known
    logic [63:0]            res;
    logic                   inv;
    logic                   sx;
    logic [ManW-1:0]        mx;
    logic [ManW-1:0]        my;
    logic signed [ExpW-1:0] ey;
    logic [CntW-1:0]        steps;
  } job_t;

  typedef struct packed {
    logic [63:0] res;
    logic        inv;
  } result_t;

endpackage

// ===== rtl/frem_fifo.sv =====
// ---------------------------------------------------------------------------
// Remainder queue
// Small register queue used between the front end, the datapath and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frem_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/frem_front.sv =====
// ---------------------------------------------------------------------------
// Remainder front end
// Classifies operands, settles special cases, normalizes both mantissas.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frem_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [63:0]     dividend_bits_i,
  input  logic [63:0]     divisor_bits_i,
  output logic            full_o,
  output logic            job_push_o,
  output frem_pkg::job_t  job_o,
  input  logic            job_full_i
);

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_NORM = 3'b010,
    FE_PUSH = 3'b100
  } fe_state_e;

  fe_state_e                        state_q, state_d;
  frem_pkg::job_t                   job_q, job_d;
  logic [63:0]                      xb_q, xb_d;
  logic [frem_pkg::ManW-1:0]        mx_q, mx_d, my_q, my_d;
  logic signed [frem_pkg::ExpW-1:0] ex_q, ex_d, ey_q, ey_d;

  logic [62:0]                      ax, ay;
  logic                             accept;
  logic signed [frem_pkg::ExpW-1:0] diff;

  assign ax         = dividend_bits_i[62:0];
  assign ay         = divisor_bits_i[62:0];
  assign full_o     = (state_q != FE_IDLE);
  assign accept     = push_i && (state_q == FE_IDLE);
  assign job_push_o = (state_q == FE_PUSH);
  assign job_o      = job_q;
  assign diff       = ex_q - ey_q + frem_pkg::ExpW'(1);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    xb_d    = xb_q;
    mx_d    = mx_q;
    my_d    = my_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    case (state_q)
      FE_IDLE: begin
        if (accept) begin
          xb_d          = dividend_bits_i;
          job_d         = '0;
          job_d.direct  = 1'b1;
          job_d.sx      = dividend_bits_i[63];
          state_d       = FE_PUSH;
          if (ax > frem_pkg::ExpAll) begin
            job_d.res = dividend_bits_i | frem_pkg::QuietBit;
            job_d.inv = 1'b1;
          end else if (ay > frem_pkg::ExpAll) begin
            job_d.res = divisor_bits_i | frem_pkg::QuietBit;
            job_d.inv = 1'b1;
          end else if (ax == frem_pkg::ExpAll || ay == '0) begin
            job_d.res = frem_pkg::DefaultNan;
            job_d.inv = 1'b1;
          end else if (ay == frem_pkg::ExpAll || ax == '0) begin
            job_d.res = dividend_bits_i;
          end else begin
            // unpack both; subnormals start at the minimum exponent
            mx_d    = {(ax[62:52] != '0), ax[51:0]};
            my_d    = {(ay[62:52] != '0), ay[51:0]};
            ex_d    = (ax[62:52] == '0) ? frem_pkg::MinExp
                    : $signed({2'b00, ax[62:52]}) - frem_pkg::ExpBias;
            ey_d    = (ay[62:52] == '0) ? frem_pkg::MinExp
                    : $signed({2'b00, ay[62:52]}) - frem_pkg::ExpBias;
            state_d = FE_NORM;
          end
        end
      end
      FE_NORM: begin
        // shift each mantissa one bit a cycle until the leading bit is set
        if (!mx_q[frem_pkg::ManW-1]) begin
          mx_d = {mx_q[frem_pkg::ManW-2:0], 1'b0};
          ex_d = ex_q - frem_pkg::ExpW'(1);
        end
        if (!my_q[frem_pkg::ManW-1]) begin
          my_d = {my_q[frem_pkg::ManW-2:0], 1'b0};
          ey_d = ey_q - frem_pkg::ExpW'(1);
        end
        if (mx_q[frem_pkg::ManW-1] && my_q[frem_pkg::ManW-1]) begin
          state_d = FE_PUSH;
          if (diff < 0) begin
            job_d.res = xb_q;
          end else begin
            job_d.direct = 1'b0;
            job_d.mx     = mx_q;
            job_d.my     = my_q;
            job_d.ey     = ey_q;
            job_d.steps  = diff[frem_pkg::CntW-1:0];
          end
        end
      end
      FE_PUSH: begin
        if (!job_full_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    xb_q  <= xb_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    ex_q  <= ex_d;
    ey_q  <= ey_d;
  end

endmodule

// ===== rtl/frem_back.sv =====
// ---------------------------------------------------------------------------
// Remainder datapath
// Shift-and-subtract modulo, round to nearest even quotient, repack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frem_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frem_pkg::job_t    job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  output logic              res_push_o,
  output frem_pkg::result_t res_o,
  input  logic              res_full_i
);

  localparam int unsigned RW = frem_pkg::ManW + 2;

  typedef enum logic [6:0] {
    BE_IDLE = 7'b0000001,
    BE_LOOP = 7'b0000010,
    BE_FIN  = 7'b0000100,
    BE_RND  = 7'b0001000,
    BE_DN   = 7'b0010000,
    BE_UP   = 7'b0100000,
    BE_OUT  = 7'b1000000
  } be_state_e;

  be_state_e                        state_q, state_d;
  logic [RW-1:0]                    r_q, r_d;
  logic [RW-1:0]                    big_q, big_d;
  logic [frem_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic signed [frem_pkg::ExpW-1:0] e_q, e_d;
  logic                             sx_q, sx_d, odd_q, odd_d, flip_q, flip_d;
  frem_pkg::result_t                res_q, res_d;

  logic [RW-1:0]                    r_red, r_dbl;
  logic signed [frem_pkg::ExpW-1:0] be;
  logic [frem_pkg::ManW-1:0]        m;

  assign job_pop_o  = (state_q == BE_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == BE_OUT);
  assign res_o      = res_q;
  assign r_red      = (r_q >= big_q) ? r_q - big_q : r_q;
  assign r_dbl      = {r_q[RW-2:0], 1'b0};
  assign m          = r_q[frem_pkg::ManW-1:0];
  assign be         = e_q + frem_pkg::ExpBias;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    big_d   = big_q;
    cnt_d   = cnt_q;
    e_d     = e_q;
    sx_d    = sx_q;
    odd_d   = odd_q;
    flip_d  = flip_q;
    res_d   = res_q;
    case (state_q)
      BE_IDLE: begin
        if (!job_empty_i) begin
          res_d.res = job_i.res;
          res_d.inv = job_i.inv;
          sx_d      = job_i.sx;
          r_d       = RW'(job_i.mx);
          big_d     = {1'b0, job_i.my, 1'b0};
          e_d       = job_i.ey - frem_pkg::ExpW'(1);
          cnt_d     = job_i.steps;
          if (job_i.direct) begin
            state_d = BE_OUT;
          end else if (job_i.steps == '0) begin
            state_d = BE_FIN;
          end else begin
            state_d = BE_LOOP;
          end
        end
      end
      BE_LOOP: begin
        r_d   = {r_red[RW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == frem_pkg::CntW'(1)) begin
          state_d = BE_FIN;
        end
      end
      BE_FIN: begin
        odd_d   = (r_q >= big_q);
        r_d     = r_red;
        state_d = BE_RND;
      end
      BE_RND: begin
        // round the quotient up past half, or at half when it is odd
        flip_d = (r_dbl > big_q) || ((r_dbl == big_q) && odd_q);
        if (flip_d) begin
          r_d = big_q - r_q;
        end
        state_d = BE_DN;
      end
      BE_DN: begin
        if (r_q == '0) begin
          res_d.res = {sx_q, 63'd0};
          state_d   = BE_OUT;
        end else if (e_q < frem_pkg::MinExp) begin
          r_d = r_q >> 1;
          e_d = e_q + frem_pkg::ExpW'(1);
        end else begin
          state_d = BE_UP;
        end
      end
      BE_UP: begin
        if (!m[frem_pkg::ManW-1] && (e_q > frem_pkg::MinExp)) begin
          r_d = {r_q[RW-2:0], 1'b0};
          e_d = e_q - frem_pkg::ExpW'(1);
        end else begin
          res_d.res[63] = sx_q ^ flip_q;
          if (m[frem_pkg::ManW-1]) begin
            res_d.res[62:0] = {be[10:0], m[51:0]};
          end else begin
            res_d.res[62:0] = {11'd0, m[51:0]};
          end
          state_d = BE_OUT;
        end
      end
      BE_OUT: begin
        if (!res_full_i) begin
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    big_q  <= big_d;
    cnt_q  <= cnt_d;
    e_q    <= e_d;
    sx_q   <= sx_d;
    odd_q  <= odd_d;
    flip_q <= flip_d;
    res_q  <= res_d;
  end

endmodule

// ===== rtl/float64_ieee_remainder.sv =====
// ---------------------------------------------------------------------------
// Binary64 IEEE remainder
// Exact x - n*y with n the quotient rounded to nearest, ties to even.
// ---------------------------------------------------------------------------
// One item at a time through each half. The front end shifts each mantissa until
// its leading bit is set; the datapath runs the modulo over d, the exponent
// difference plus one (at most 2098), then rounds and renormalizes the result
// one bit a cycle; the modulo retires one quotient bit per cycle. Special
// operands skip the modulo. A job queue lets the front end normalize the
// next item while the datapath works.
`timescale 1ns / 1ps

`include "float64_ieee_remainder_defines.svh"

module float64_ieee_remainder #(
  parameter int unsigned JobDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] dividend_bits_i,
  input  logic [63:0] divisor_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] remainder_bits_o,
  output logic        invalid_flag_o
);

  frem_pkg::job_t    fe_job, be_job;
  logic              fe_push, job_full, job_empty, be_pop;
  frem_pkg::result_t be_res, out_res;
  logic              be_push, res_full;
  logic              out_exp_ones, out_nan;

  frem_front u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .dividend_bits_i,
    .divisor_bits_i,
    .full_o          (full),
    .job_push_o      (fe_push),
    .job_o           (fe_job),
    .job_full_i      (job_full)
  );

  frem_fifo #(
    .Width ($bits(frem_pkg::job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i,
    .rst_ni,
    .push_i  (fe_push),
    .data_i  (fe_job),
    .full_o  (job_full),
    .pop_i   (be_pop),
    .data_o  (be_job),
    .empty_o (job_empty)
  );

  frem_back u_back (
    .clk_i,
    .rst_ni,
    .job_i       (be_job),
    .job_empty_i (job_empty),
    .job_pop_o   (be_pop),
    .res_push_o  (be_push),
    .res_o       (be_res),
    .res_full_i  (res_full)
  );

  frem_fifo #(
    .Width ($bits(frem_pkg::result_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (be_push),
    .data_i  (be_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign remainder_bits_o = out_res.res;
  assign invalid_flag_o   = out_res.inv;
  assign out_exp_ones     = (remainder_bits_o[62:52] == 11'h7FF);
  assign out_nan          = out_exp_ones && remainder_bits_o[51];

  `FREM_ASSERT(a_nan_flag, !empty && invalid_flag_o |-> out_nan, "NaN result is not quiet")
  `FREM_ASSERT(a_no_inf, !empty && !invalid_flag_o |-> !out_exp_ones, "valid result not finite")
  `FREM_ASSERT(a_job_hold, fe_push && job_full |=> fe_push && $stable(fe_job), "stalled job moved")
  `FREM_ASSERT(a_res_hold, be_push && res_full |=> be_push && $stable(be_res), "stalled result moved")

endmodule

// ===== dv/float64_ieee_remainder_test.sv =====
// ---------------------------------------------------------------------------
// Binary64 IEEE remainder testbench
// Directed special operands, then random and structured operand pairs under
// three idling patterns; every result is checked against a built-in predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module float64_ieee_remainder_test;

  localparam logic [63:0] SignBit  = 64'h8000000000000000;
  localparam logic [63:0] FracMask = 64'h000FFFFFFFFFFFFF;
  localparam logic [63:0] Hidden   = 64'h0010000000000000;
  localparam logic [63:0] PosInf   = 64'h7FF0000000000000;
  localparam int          LowExp   = -1074;
  localparam longint      CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [63:0] dividend_bits_i;
  logic [63:0] divisor_bits_i;
  logic        empty;
  logic        pop;
  logic [63:0] remainder_bits_o;
  logic        invalid_flag_o;

  typedef struct {
    logic [63:0] rem;
    logic        inv;
  } rem_result_t;

  rem_result_t expected_rems[$];
  int          error_count;
  int          checked_count;
  longint      cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  float64_ieee_remainder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .dividend_bits_i (dividend_bits_i),
    .divisor_bits_i  (divisor_bits_i),
    .empty           (empty),
    .pop             (pop),
    .remainder_bits_o(remainder_bits_o),
    .invalid_flag_o  (invalid_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rems.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Normalize a finite nonzero magnitude to mant * 2^ex with bit 52 set.
  function automatic void split_mag(input logic [63:0] mag, output logic [63:0] mant,
                                    output int ex);
    mant = mag & FracMask;
    if (mag[62:52] == 0) ex = LowExp;
    else begin
      mant = mant | Hidden;
      ex = int'(mag[62:52]) - 1075;
    end
    while (mant < Hidden) begin
      mant = mant << 1;
      ex--;
    end
  endfunction

  function automatic logic [63:0] join_mag(logic [63:0] mant, int ex);
    if (mant == 0) return 64'd0;
    while (ex < LowExp) begin
      mant = mant >> 1;
      ex++;
    end
    while (mant < Hidden && ex > LowExp) begin
      mant = mant << 1;
      ex--;
    end
    if (mant < Hidden) return mant;
    return (64'(ex + 1075) << 52) | (mant & FracMask);
  endfunction

  function automatic rem_result_t predict_remainder(logic [63:0] xb, logic [63:0] yb);
    rem_result_t res;
    logic [63:0] sx, ax, ay, mx, my, twice_y, acc, mag;
    int ex, ey, diff;
    logic odd, flip;
    sx = xb & SignBit;
    ax = xb & ~SignBit;
    ay = yb & ~SignBit;
    res.inv = 1'b0;
    if (ax > PosInf) begin
      res.rem = xb | frem_pkg::QuietBit;
      res.inv = 1'b1;
      return res;
    end
    if (ay > PosInf) begin
      res.rem = yb | frem_pkg::QuietBit;
      res.inv = 1'b1;
      return res;
    end
    if (ax == PosInf || ay == 0) begin
      res.rem = frem_pkg::DefaultNan;
      res.inv = 1'b1;
      return res;
    end
    res.rem = xb;
    if (ay == PosInf || ax == 0) return res;
    split_mag(ax, mx, ex);
    split_mag(ay, my, ey);
    if (ex < ey - 1) return res;
    twice_y = my << 1;
    diff = ex - (ey - 1);
    acc = mx;
    for (int i = 0; i < diff; i++) begin
      if (acc >= twice_y) acc = acc - twice_y;
      acc = acc << 1;
    end
    odd = 1'b0;
    if (acc >= twice_y) begin
      acc = acc - twice_y;
      odd = 1'b1;
    end
    flip = 1'b0;
    if ((acc << 1) > twice_y || ((acc << 1) == twice_y && odd)) begin
      acc = twice_y - acc;
      flip = 1'b1;
    end
    mag = join_mag(acc, ey - 1);
    if (mag == 0) res.rem = sx;
    else res.rem = mag | (flip ? (sx ^ SignBit) : sx);
    return res;
  endfunction

  // Check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    rem_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_rems.size() == 0) begin
        $display("%0t: unexpected result rem=%h inv=%b", $time, remainder_bits_o,
                 invalid_flag_o);
        error_count++;
      end else begin
        want = expected_rems.pop_front();
        checked_count++;
        if (remainder_bits_o !== want.rem) begin
          $display("%0t: remainder mismatch expected %h actual %h", $time, want.rem,
                   remainder_bits_o);
          error_count++;
        end
        if (invalid_flag_o !== want.inv) begin
          $display("%0t: invalid flag mismatch expected %b actual %b", $time, want.inv,
                   invalid_flag_o);
          error_count++;
        end
      end
    end
    if (rst_ni) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Leave push as it is after the transaction; the next call drives it anew, or the drain drops it.
  task automatic send_operands(input logic [63:0] xb, input logic [63:0] yb);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    dividend_bits_i <= xb;
    divisor_bits_i  <= yb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_rems.push_back(predict_remainder(xb, yb));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand with an exponent near a chosen center, so most pairs do real work.
  function automatic logic [63:0] near_exp(int center, int spread);
    int e;
    e = center + int'($urandom_range(2 * spread)) - spread;
    if (e < 0) e = 0;
    if (e > 2046) e = 2046;
    return {1'($urandom()), 11'(e), 52'(rand64())};
  endfunction

  task automatic test_special_operands();
    logic [63:0] qnan, snan, one, three, huge, tiny;
    qnan  = 64'h7FF8000000000001;
    snan  = 64'hFFF0000000000005;
    one   = 64'h3FF0000000000000;
    three = 64'h4008000000000000;
    huge  = 64'h7FEFFFFFFFFFFFFF;
    tiny  = 64'h0000000000000001;
    send_operands(snan, one);
    send_operands(qnan, snan);
    send_operands(one, snan);
    send_operands(PosInf, one);
    send_operands(PosInf | SignBit, qnan & ~64'h1 | 64'h4);
    send_operands(one, 64'd0);
    send_operands(one, SignBit);
    send_operands(SignBit | three, PosInf);
    send_operands(SignBit, three);
    send_operands(64'd0, tiny);
    send_operands(64'h3FE0000000000000, one);   // exact half: tie keeps n = 0
    send_operands(64'h3FF8000000000000, one);   // 1.5: tie to even, n = 2
    send_operands(64'h4004000000000000, one);   // 2.5: tie to even, n = 2
    send_operands(three, one);                  // exact multiple
    send_operands(SignBit | three, one);        // negative zero result
    send_operands(huge, tiny);                  // longest modulo
    send_operands(tiny, huge);
    send_operands(huge, 64'h000FFFFFFFFFFFFF);
    send_operands(64'h000FFFFFFFFFFFFF, 64'h0000000000000003);
    send_operands(64'h3FF0000000000001, 64'h3FEFFFFFFFFFFFFF);
    send_operands(64'h0010000000000000, 64'h0000000000000003);
    send_operands(~64'd0, ~64'd0);
  endtask

  task automatic test_random_operands(input int count);
    int kind, ce;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      ce = $urandom_range(2046);
      case (kind)
        0: send_operands(rand64(), rand64());
        1: send_operands(near_exp(ce, 3), near_exp(ce, 3));
        2: send_operands(near_exp(ce, 60), near_exp(ce, 2));
        3: send_operands(near_exp(3, 3), near_exp(2, 2));    // subnormal region
        4: send_operands(near_exp(ce, 1) & ~64'hFFFFFFFF, near_exp(ce, 1) & ~64'hFFFFFFFF);
        5: send_operands(near_exp(ce, 30), {1'($urandom()), 63'(PosInf)} |
                         ($urandom_range(1) ? 64'(($urandom() | 1)) : 64'd0));
        default: send_operands(near_exp(ce, 8), near_exp(ce, 8));
      endcase
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_rems.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    error_count     = 0;
    checked_count   = 0;
    cycle_count     = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 60;
    rst_ni          = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    dividend_bits_i = '0;
    divisor_bits_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_operands();
    test_random_operands(86);
    send_idle_pct = 60;
    recv_idle_pct = 15;
    test_random_operands(86);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_operands(86);
    drain_results();
    $display("Checked %0d remainder results: special operands, ties, subnormals,",
             checked_count);
    $display("and random operand pairs under three idling patterns.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
